[design/vte_pkg.sv]
// ----------------------------------------------------------------------------
// vte_pkg
// shared widths, operation codes and status codes of the vlan table engine
// ----------------------------------------------------------------------------
package vte_pkg;

    localparam int VID_W  = 12;
    localparam int MASK_W = 6;
    localparam int OP_W   = 3;
    localparam int PORT_W = 4;
    localparam int EIDX_W = 3;
    localparam int ST_W   = 2;
    localparam int DFLT_W = 4;

    localparam logic [VID_W-1:0]  VID_MAX      = 12'd4094;
    localparam logic [VID_W-1:0]  VID_BOOT     = 12'd1;
    localparam logic [MASK_W-1:0] MASK_BOOT    = 6'h1F;

    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
    localparam logic [OP_W-1:0] OP_SETDEF  = 3'd2;
    localparam logic [OP_W-1:0] OP_ADDMEM  = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

[design/vlan_table_engine_top.sv]
// ----------------------------------------------------------------------------
// vlan_table_engine_top
// vlan table with per-entry id, member masks in a synchronous ram and
// per-port default entry indices
//
//   channel   handshake          fields
//   request   start / busy       op vlan_id port_num entry_index member_mask
//   result    done (one cycle)   status vid_out mask_out slot_out
//
// the accept edge of a request searches the ids and issues the member ram
// read, the next edge does the modify and write back and loads the result
// registers. done is high in the cycle after that, when busy is already
// low, so a new request can be accepted while done is high.
// reset loads entry 0 with id 1 and mask 0x1f and needs no clearing pass.
// the receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module vlan_table_engine_top #(
    parameter int NUM_ENTRIES = 5,
    parameter int NUM_PORTS   = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [vte_pkg::OP_W-1:0]      op,
    input  logic [vte_pkg::VID_W-1:0]     vlan_id,
    input  logic [vte_pkg::PORT_W-1:0]    port_num,
    input  logic [vte_pkg::EIDX_W-1:0]    entry_index,
    input  logic [vte_pkg::MASK_W-1:0]    member_mask,
    output logic                          done,
    output logic [vte_pkg::ST_W-1:0]      status,
    output logic [vte_pkg::VID_W-1:0]     vid_out,
    output logic [vte_pkg::MASK_W-1:0]    mask_out,
    output logic [vte_pkg::EIDX_W-1:0]    slot_out
);

    import vte_pkg::*;

    localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int PIDX_W = $clog2(NUM_PORTS);

    state_t state_reg, state_next;

    logic [VID_W-1:0]  vid_reg [NUM_ENTRIES];
    logic [VID_W-1:0]  vid_next [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic boot_reg, boot_next;
    logic [DFLT_W-1:0] dflt_reg [NUM_PORTS];
    logic [DFLT_W-1:0] dflt_next [NUM_PORTS];

    logic [MASK_W-1:0] member_ram [NUM_ENTRIES];
    logic [MASK_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [MASK_W-1:0] wr_data;

    logic [OP_W-1:0]   op_reg;
    logic [VID_W-1:0]  req_vid_reg;
    logic [PORT_W-1:0] req_port_reg;
    logic [EIDX_W-1:0] req_eidx_reg;
    logic [MASK_W-1:0] req_mask_reg;
    logic              hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic              empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]  empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]  addr_reg;

    logic              done_reg;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [VID_W-1:0]  vid_out_reg, vid_out_next;
    logic [MASK_W-1:0] mask_out_reg, mask_out_next;
    logic [EIDX_W-1:0] slot_out_reg, slot_out_next;

    logic                    accept;
    logic [IDX_W+EIDX_W-1:0] in_idx_ext;
    logic [IDX_W-1:0]        in_idx;
    logic [IDX_W+EIDX_W-1:0] req_idx_ext;
    logic [IDX_W-1:0]        req_idx;
    logic                    req_vid_ok;
    logic                    req_port_ok;
    logic                    req_idx_ok;
    logic [MASK_W-1:0]       cur_mask;
    logic [MASK_W-1:0]       port_bit;
    logic [NUM_PORTS-1:0]    port_ok_vec;

    function automatic logic [EIDX_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+EIDX_W-1:0] ext;
        ext = {{EIDX_W{1'b0}}, idx};
        return ext[EIDX_W-1:0];
    endfunction

    function automatic logic [DFLT_W-1:0] to_dflt(input logic [IDX_W-1:0] idx);
        logic [IDX_W+DFLT_W-1:0] ext;
        ext = {{DFLT_W{1'b0}}, idx};
        return ext[DFLT_W-1:0];
    endfunction

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);

    assign in_idx_ext  = {{IDX_W{1'b0}}, entry_index};
    assign in_idx      = in_idx_ext[IDX_W-1:0];
    assign req_idx_ext = {{IDX_W{1'b0}}, req_eidx_reg};
    assign req_idx     = req_idx_ext[IDX_W-1:0];

    // lowest matching and lowest empty entry
    always_comb
    begin
        hit_found_next   = 1'b0;
        hit_idx_next     = '0;
        empty_found_next = 1'b0;
        empty_idx_next   = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (vid_reg[i] == vlan_id)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = IDX_W'(i);
            end
            if (vid_reg[i] == '0)
            begin
                empty_found_next = 1'b1;
                empty_idx_next   = IDX_W'(i);
            end
        end
    end

    assign rd_addr = (op == OP_READ) ? in_idx : hit_idx_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            member_ram[wr_addr] <= wr_data;
        end
        rd_data_reg <= member_ram[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg          <= op;
            req_vid_reg     <= vlan_id;
            req_port_reg    <= port_num;
            req_eidx_reg    <= entry_index;
            req_mask_reg    <= member_mask;
            hit_found_reg   <= hit_found_next;
            hit_idx_reg     <= hit_idx_next;
            empty_found_reg <= empty_found_next;
            empty_idx_reg   <= empty_idx_next;
            addr_reg        <= rd_addr;
        end
    end

    always_comb
    begin
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            port_ok_vec[p] = (req_port_reg == PORT_W'(p));
        end
    end

    assign req_vid_ok  = (req_vid_reg != '0) && (req_vid_reg <= VID_MAX);
    assign req_port_ok = |port_ok_vec;
    assign req_idx_ok  = (32'(req_eidx_reg) < NUM_ENTRIES);
    assign port_bit    = MASK_W'(1) << req_port_reg[PIDX_W-1:0];

    // entries never written since reset read as their reset mask; after a clear they read as zero
    always_comb
    begin
        if (valid_reg[addr_reg])
        begin
            cur_mask = rd_data_reg;
        end
        else if (boot_reg && (addr_reg == '0))
        begin
            cur_mask = MASK_BOOT;
        end
        else
        begin
            cur_mask = '0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        vid_next      = vid_reg;
        valid_next    = valid_reg;
        boot_next     = boot_reg;
        dflt_next     = dflt_reg;
        wr_en         = 1'b0;
        wr_addr       = addr_reg;
        wr_data       = '0;
        status_next   = ST_BAD;
        vid_out_next  = '0;
        mask_out_next = '0;
        slot_out_next = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (op_reg)
                    OP_CLEAR:
                    begin
                        for (int i = 0; i < NUM_ENTRIES; i++)
                        begin
                            vid_next[i] = '0;
                        end
                        valid_next  = '0;
                        boot_next   = 1'b0;
                        status_next = ST_OK;
                    end
                    OP_ADD:
                    begin
                        if (req_vid_ok)
                        begin
                            if (hit_found_reg)
                            begin
                                status_next   = ST_OK;
                                slot_out_next = to_slot(hit_idx_reg);
                            end
                            else if (empty_found_reg)
                            begin
                                vid_next[empty_idx_reg]   = req_vid_reg;
                                valid_next[empty_idx_reg] = 1'b1;
                                wr_en         = 1'b1;
                                wr_addr       = empty_idx_reg;
                                wr_data       = '0;
                                status_next   = ST_OK;
                                slot_out_next = to_slot(empty_idx_reg);
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                    end
                    OP_SETDEF, OP_ADDMEM:
                    begin
                        if (req_vid_ok && req_port_ok)
                        begin
                            if (hit_found_reg)
                            begin
                                if (op_reg == OP_ADDMEM)
                                begin
                                    valid_next[hit_idx_reg] = 1'b1;
                                    wr_en   = 1'b1;
                                    wr_addr = hit_idx_reg;
                                    wr_data = cur_mask | port_bit;
                                end
                                else
                                begin
                                    dflt_next[req_port_reg[PIDX_W-1:0]] =
                                        to_dflt(hit_idx_reg);
                                end
                                status_next   = ST_OK;
                                slot_out_next = to_slot(hit_idx_reg);
                            end
                            else
                            begin
                                status_next = ST_NOTFOUND;
                            end
                        end
                    end
                    OP_WRITE:
                    begin
                        if (req_idx_ok)
                        begin
                            vid_next[req_idx]   = req_vid_reg;
                            valid_next[req_idx] = 1'b1;
                            wr_en         = 1'b1;
                            wr_addr       = req_idx;
                            wr_data       = req_mask_reg;
                            status_next   = ST_OK;
                            slot_out_next = req_eidx_reg;
                        end
                    end
                    OP_READ:
                    begin
                        if (req_idx_ok)
                        begin
                            vid_out_next  = vid_reg[req_idx];
                            mask_out_next = cur_mask;
                            status_next   = ST_OK;
                            slot_out_next = req_eidx_reg;
                        end
                    end
                    default:
                    begin
                        status_next = ST_BAD;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            valid_reg <= '0;
            boot_reg  <= 1'b1;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                vid_reg[i] <= (i == 0) ? VID_BOOT : '0;
            end
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                dflt_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
            valid_reg <= valid_next;
            boot_reg  <= boot_next;
            vid_reg   <= vid_next;
            dflt_reg  <= dflt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            status_reg   <= status_next;
            vid_out_reg  <= vid_out_next;
            mask_out_reg <= mask_out_next;
            slot_out_reg <= slot_out_next;
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign vid_out  = vid_out_reg;
    assign mask_out = mask_out_reg;
    assign slot_out = slot_out_reg;

`ifndef SYNTH
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not enter execute");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> done_reg)
        else $error("execute cycle not followed by result strobe");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while busy");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != ST_OK)) |->
        ((vid_out_reg == '0) && (mask_out_reg == '0) && (slot_out_reg == '0)))
        else $error("rejected transaction returned nonzero fields");

    a_write_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_EXEC))
        else $error("member ram written outside execute");
`endif

endmodule

[tb/vlan_table_engine_checker.sv]
// ----------------------------------------------------------------------------
// vlan_table_engine_checker
// watches the request and result channels of the vlan table engine, keeps
// its own copy of the id, member and default-entry tables, works out the
// result of every accepted request and compares each done strobe against
// the oldest outstanding expectation, field by field
// ----------------------------------------------------------------------------
module vlan_table_engine_checker #(
    parameter int NUM_ENTRIES = 5,
    parameter int NUM_PORTS   = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [vte_pkg::OP_W-1:0]      op,
    input  logic [vte_pkg::VID_W-1:0]     vlan_id,
    input  logic [vte_pkg::PORT_W-1:0]    port_num,
    input  logic [vte_pkg::EIDX_W-1:0]    entry_index,
    input  logic [vte_pkg::MASK_W-1:0]    member_mask,
    input  logic                          done,
    input  logic [vte_pkg::ST_W-1:0]      status,
    input  logic [vte_pkg::VID_W-1:0]     vid_out,
    input  logic [vte_pkg::MASK_W-1:0]    mask_out,
    input  logic [vte_pkg::EIDX_W-1:0]    slot_out,
    output int                            mismatch_count,
    output int                            open_count
);

    import vte_pkg::*;

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [VID_W-1:0]  vid;
        logic [MASK_W-1:0] mask;
        logic [EIDX_W-1:0] slot;
    } table_reply_t;

    logic [VID_W-1:0]  vid_tbl   [NUM_ENTRIES];
    logic [MASK_W-1:0] mbr_tbl   [NUM_ENTRIES];
    logic [3:0]        dflt_slot [NUM_PORTS];

    table_reply_t replies_due[$];
    int           errs  = 0;
    int           n_due = 0;

    assign mismatch_count = errs;
    assign open_count     = n_due;

    task automatic report_mismatch(input string what);
        if (errs < PRINT_CAP)
        begin
            $display("%0t vlan_table_engine_checker: %s", $time, what);
        end
        errs++;
    endtask

    function automatic void reset_tables();
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            vid_tbl[i] = '0;
            mbr_tbl[i] = '0;
        end
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            dflt_slot[i] = '0;
        end
        vid_tbl[0] = VID_BOOT;
        mbr_tbl[0] = MASK_BOOT;
    endfunction

    function automatic int lowest_holding(input logic [VID_W-1:0] v);
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (vid_tbl[i] == v)
            begin
                return i;
            end
        end
        return NUM_ENTRIES;
    endfunction

    function automatic table_reply_t apply_request(
        input logic [OP_W-1:0]   rop,
        input logic [VID_W-1:0]  vid,
        input logic [PORT_W-1:0] port,
        input logic [EIDX_W-1:0] idx,
        input logic [MASK_W-1:0] mask
    );
        table_reply_t r;
        int           hit;
        logic         vid_valid;
        logic         port_valid;
        logic         idx_valid;
        r          = '0;
        r.status   = ST_BAD;
        vid_valid  = (vid >= VID_BOOT) && (vid <= VID_MAX);
        port_valid = (int'(port) < NUM_PORTS);
        idx_valid  = (int'(idx) < NUM_ENTRIES);
        case (rop)
            OP_CLEAR:
            begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    vid_tbl[i] = '0;
                    mbr_tbl[i] = '0;
                end
                r.status = ST_OK;
            end
            OP_ADD:
            begin
                if (vid_valid)
                begin
                    hit = lowest_holding(vid);
                    if (hit < NUM_ENTRIES)
                    begin
                        r.status = ST_OK;
                        r.slot   = hit[EIDX_W-1:0];
                    end
                    else
                    begin
                        hit = lowest_holding('0);
                        if (hit >= NUM_ENTRIES)
                        begin
                            r.status = ST_FULL;
                        end
                        else
                        begin
                            vid_tbl[hit] = vid;
                            mbr_tbl[hit] = '0;
                            r.status     = ST_OK;
                            r.slot       = hit[EIDX_W-1:0];
                        end
                    end
                end
            end
            OP_SETDEF, OP_ADDMEM:
            begin
                if (vid_valid && port_valid)
                begin
                    hit = lowest_holding(vid);
                    if (hit >= NUM_ENTRIES)
                    begin
                        r.status = ST_NOTFOUND;
                    end
                    else
                    begin
                        if (rop == OP_SETDEF)
                        begin
                            dflt_slot[port] = hit[3:0];
                        end
                        else
                        begin
                            mbr_tbl[hit][port] = 1'b1;
                        end
                        r.status = ST_OK;
                        r.slot   = hit[EIDX_W-1:0];
                    end
                end
            end
            OP_WRITE:
            begin
                if (idx_valid)
                begin
                    vid_tbl[idx] = vid;
                    mbr_tbl[idx] = mask;
                    r.status     = ST_OK;
                    r.slot       = idx;
                end
            end
            OP_READ:
            begin
                if (idx_valid)
                begin
                    r.vid    = vid_tbl[idx];
                    r.mask   = mbr_tbl[idx];
                    r.status = ST_OK;
                    r.slot   = idx;
                end
            end
            default:
            begin
                r.status = ST_BAD;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        table_reply_t want;
        if (!rst_n)
        begin
            reset_tables();
        end
        else
        begin
            if (done)
            begin
                if (replies_due.size() == 0)
                begin
                    report_mismatch("result with no transaction outstanding");
                end
                else
                begin
                    want = replies_due.pop_front();
                    n_due--;
                    if (status !== want.status)
                    begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  status, want.status));
                    end
                    if (vid_out !== want.vid)
                    begin
                        report_mismatch($sformatf("vid_out got %0d want %0d",
                                                  vid_out, want.vid));
                    end
                    if (mask_out !== want.mask)
                    begin
                        report_mismatch($sformatf("mask_out got 0x%0h want 0x%0h",
                                                  mask_out, want.mask));
                    end
                    if (slot_out !== want.slot)
                    begin
                        report_mismatch($sformatf("slot_out got %0d want %0d",
                                                  slot_out, want.slot));
                    end
                end
            end
            if (start && !busy)
            begin
                replies_due.push_back(apply_request(op, vlan_id, port_num,
                                                    entry_index, member_mask));
                n_due++;
            end
        end
    end

endmodule

[tb/vlan_table_engine_top_tb.sv]
// ----------------------------------------------------------------------------
// vlan_table_engine_top_tb
// drives the vlan table engine with a directed run over the field limits,
// every operation and the full, missing and out-of-range cases, then with
// random requests drawn from a small id pool so lookups hit, under several
// idle patterns; checking is done by the checker beside the engine
// ----------------------------------------------------------------------------
module vlan_table_engine_top_tb;
    import vte_pkg::*;

    localparam int NUM_ENTRIES  = 5;
    localparam int NUM_PORTS    = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CHUNK_ITEMS  = 150;
    localparam int NUM_CHUNKS   = 8;
    localparam int TAIL_CYCLES  = 8;
    localparam int POOL_SIZE    = 6;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [OP_W-1:0]      op;
    logic [VID_W-1:0]     vlan_id;
    logic [PORT_W-1:0]    port_num;
    logic [EIDX_W-1:0]    entry_index;
    logic [MASK_W-1:0]    member_mask;
    logic                 done;
    logic [ST_W-1:0]      status;
    logic [VID_W-1:0]     vid_out;
    logic [MASK_W-1:0]    mask_out;
    logic [EIDX_W-1:0]    slot_out;
    int                   mismatch_count;
    int                   open_count;

    int                   cycle_count = 0;
    int                   idle_pct    = 0;
    logic [VID_W-1:0]     vid_pool [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    vlan_table_engine_top #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .NUM_PORTS   (NUM_PORTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .vlan_id     (vlan_id),
        .port_num    (port_num),
        .entry_index (entry_index),
        .member_mask (member_mask),
        .done        (done),
        .status      (status),
        .vid_out     (vid_out),
        .mask_out    (mask_out),
        .slot_out    (slot_out)
    );

    vlan_table_engine_checker #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .NUM_PORTS   (NUM_PORTS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .vlan_id        (vlan_id),
        .port_num       (port_num),
        .entry_index    (entry_index),
        .member_mask    (member_mask),
        .done           (done),
        .status         (status),
        .vid_out        (vid_out),
        .mask_out       (mask_out),
        .slot_out       (slot_out),
        .mismatch_count (mismatch_count),
        .open_count     (open_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("vlan_table_engine_top_tb: done, errors");
            $finish;
        end
    end

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic issue_request(
        input logic [OP_W-1:0]   rop,
        input logic [VID_W-1:0]  vid,
        input logic [PORT_W-1:0] port,
        input logic [EIDX_W-1:0] idx,
        input logic [MASK_W-1:0] mask
    );
        while ($urandom_range(99) < idle_pct)
        begin
            idle_cycle();
        end
        @(negedge clk);
        start       <= 1'b1;
        op          <= rop;
        vlan_id     <= vid;
        port_num    <= port;
        entry_index <= idx;
        member_mask <= mask;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic wait_for_results();
        idle_cycle();
        while (open_count != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [VID_W-1:0] pick_vid();
        int r;
        r = $urandom_range(99);
        if (r < 80)
        begin
            return vid_pool[$urandom_range(POOL_SIZE - 1)];
        end
        else if (r < 87)
        begin
            return '0;
        end
        else if (r < 93)
        begin
            return '1;
        end
        return VID_W'($urandom_range(4095));
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        if ($urandom_range(99) < 85)
        begin
            return PORT_W'($urandom_range(NUM_PORTS - 1));
        end
        return PORT_W'($urandom_range(15));
    endfunction

    function automatic logic [EIDX_W-1:0] pick_index();
        if ($urandom_range(99) < 85)
        begin
            return EIDX_W'($urandom_range(NUM_ENTRIES - 1));
        end
        return EIDX_W'($urandom_range(7));
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 3)
        begin
            return OP_CLEAR;
        end
        else if (r < 22)
        begin
            return OP_ADD;
        end
        else if (r < 37)
        begin
            return OP_SETDEF;
        end
        else if (r < 57)
        begin
            return OP_ADDMEM;
        end
        else if (r < 72)
        begin
            return OP_WRITE;
        end
        else if (r < 95)
        begin
            return OP_READ;
        end
        else if (r < 97)
        begin
            return OP_SPARE_LO;
        end
        return OP_SPARE_HI;
    endfunction

    task automatic refresh_pool();
        vid_pool[0] = VID_BOOT;
        vid_pool[1] = VID_MAX;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            vid_pool[i] = VID_W'($urandom_range(4094, 1));
        end
    endtask

    initial
    begin
        int pct_by_chunk [NUM_CHUNKS];
        pct_by_chunk = '{0, 54, 14, 0, 54, 14, 54, 0};
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = OP_CLEAR;
        vlan_id     = '0;
        port_num    = '0;
        entry_index = '0;
        member_mask = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset contents, the last index and an out-of-range index
        issue_request(OP_READ,     12'd0,    4'd0,  3'd0, 6'h00);
        issue_request(OP_READ,     12'd0,    4'd0,  3'd4, 6'h00);
        issue_request(OP_READ,     12'd0,    4'd0,  3'd7, 6'h00);
        // add: bad ids, new id, existing id
        issue_request(OP_ADD,      12'd0,    4'd0,  3'd0, 6'h00);
        issue_request(OP_ADD,      12'hFFF,  4'd0,  3'd0, 6'h00);
        issue_request(OP_ADD,      VID_MAX,  4'd0,  3'd0, 6'h00);
        issue_request(OP_ADD,      VID_BOOT, 4'd0,  3'd0, 6'h00);
        // set default: hit, bad port, missing id
        issue_request(OP_SETDEF,   VID_MAX,  4'd4,  3'd0, 6'h00);
        issue_request(OP_SETDEF,   VID_MAX,  4'd5,  3'd0, 6'h00);
        issue_request(OP_SETDEF,   12'd100,  4'd0,  3'd0, 6'h00);
        // add member: hit, bad id, bad port
        issue_request(OP_ADDMEM,   VID_MAX,  4'd4,  3'd0, 6'h00);
        issue_request(OP_ADDMEM,   12'd0,    4'd1,  3'd0, 6'h00);
        issue_request(OP_ADDMEM,   VID_BOOT, 4'd15, 3'd0, 6'h00);
        // write: bad index, all-ones id, duplicate id, then read back
        issue_request(OP_WRITE,    12'd7,    4'd0,  3'd5, 6'h3F);
        issue_request(OP_WRITE,    12'hFFF,  4'd0,  3'd2, 6'h3F);
        issue_request(OP_WRITE,    VID_MAX,  4'd0,  3'd3, 6'h2A);
        issue_request(OP_READ,     12'd0,    4'd0,  3'd2, 6'h00);
        // fill the last slot, then the table is full
        issue_request(OP_ADD,      12'd10,   4'd0,  3'd0, 6'h00);
        issue_request(OP_ADD,      12'd11,   4'd0,  3'd0, 6'h00);
        issue_request(OP_ADDMEM,   VID_MAX,  4'd0,  3'd0, 6'h00);
        issue_request(OP_READ,     12'd0,    4'd0,  3'd1, 6'h00);
        // unused codes, clear
        issue_request(OP_SPARE_LO, 12'd5,    4'd1,  3'd1, 6'h01);
        issue_request(OP_SPARE_HI, 12'd5,    4'd1,  3'd1, 6'h01);
        issue_request(OP_CLEAR,    12'd0,    4'd0,  3'd0, 6'h00);
        issue_request(OP_READ,     12'd0,    4'd0,  3'd0, 6'h00);
        wait_for_results();

        for (int c = 0; c < NUM_CHUNKS; c++)
        begin
            idle_pct = pct_by_chunk[c];
            refresh_pool();
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                issue_request(pick_op(), pick_vid(), pick_port(), pick_index(),
                              MASK_W'($urandom_range(63)));
            end
            // hold off until the engine has answered everything
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && open_count == 0)
        begin
            $display("vlan_table_engine_top_tb: done, clean");
        end
        else
        begin
            $display("vlan_table_engine_top_tb: done, errors");
        end
        $finish;
    end

endmodule
